### src/klex_pkg.sv
// klex_pkg: token type, token kind codes, keyword match states and character
// constants for the keyword token lexer. No dependencies.
package klex_pkg;

	typedef enum logic [2:0] {
		KIND_IDENT   = 3'd0,
		KIND_INT     = 3'd1,
		KIND_INPUT   = 3'd2,
		KIND_OUTPUT  = 3'd3,
		KIND_ASSIGN  = 3'd4,
		KIND_COLON   = 3'd5,
		KIND_INVALID = 3'd6,
		KIND_END     = 3'd7
	} kind_t;

	// keyword prefix matched so far inside a word
	typedef enum logic [3:0] {
		KW_NONE   = 4'd0,
		KW_I      = 4'd1,
		KW_IN     = 4'd2,
		KW_INT    = 4'd3,
		KW_INP    = 4'd4,
		KW_INPU   = 4'd5,
		KW_INPUT  = 4'd6,
		KW_O      = 4'd7,
		KW_OU     = 4'd8,
		KW_OUT    = 4'd9,
		KW_OUTP   = 4'd10,
		KW_OUTPU  = 4'd11,
		KW_OUTPUT = 4'd12
	} kw_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] word_length;
		logic [7:0] char_code;
		logic       last;
	} token_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] CH_LC_I  = 8'h69;
	localparam logic [7:0] CH_LC_N  = 8'h6E;
	localparam logic [7:0] CH_LC_O  = 8'h6F;
	localparam logic [7:0] CH_LC_P  = 8'h70;
	localparam logic [7:0] CH_LC_T  = 8'h74;
	localparam logic [7:0] CH_LC_U  = 8'h75;

	localparam int QUEUE_DEPTH = 4;

endpackage

### src/keyword_token_lexer.sv
// keyword_token_lexer: top level, byte scanner followed by a token queue.
// Depends on klex_pkg, klex_scan, klex_tok_fifo.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_ready, ch                         | in
//  output  | out_valid, out_ready, tok_kind, word_length,   | out
//          | char_code, last                                |
//
// One byte per cycle is taken while the queue has room; each byte is registered
// and decoded from that register. The queue drains one token per cycle while
// out_ready is high; a byte that closes a word and has its own token pushes two.
// Input stalls when the four-entry queue cannot take two more tokens.
// Reset clears the word state and empties the queue; no clearing pass.
module keyword_token_lexer #(
	parameter int MAX_WORD = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [2:0] tok_kind,
	output logic [7:0] word_length,
	output logic [7:0] char_code,
	output logic       last,
	output logic       out_valid,
	input  logic       out_ready
);

	logic             room;
	logic [1:0]       push_n;
	klex_pkg::token_t tok0;
	klex_pkg::token_t tok1;
	klex_pkg::token_t out_tok;

	klex_scan #(
		.MAX_WORD(MAX_WORD)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (ch),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.room     (room),
		.push_n   (push_n),
		.tok0     (tok0),
		.tok1     (tok1)
	);

	klex_tok_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.tok0      (tok0),
		.tok1      (tok1),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_tok   (out_tok)
	);

	assign tok_kind    = out_tok.kind;
	assign word_length = out_tok.word_length;
	assign char_code   = out_tok.char_code;
	assign last        = out_tok.last;

endmodule

### src/klex_scan.sv
// klex_scan: input byte register, word/keyword state and token decode.
// Emits up to two tokens per byte. Depends on klex_pkg.
module klex_scan #(
	parameter int MAX_WORD = 255
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        ch,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              room,
	output logic [1:0]        push_n,
	output klex_pkg::token_t  tok0,
	output klex_pkg::token_t  tok1
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_WORD);

	logic            valid_s1;
	logic [7:0]      ch_s1;
	logic            in_word_q;
	logic [7:0]      count_q;
	klex_pkg::kw_t   kw_q;

	logic            take;
	logic            is_letter;
	logic            is_space;
	logic            word_end;
	logic            own;
	klex_pkg::kw_t   kw_next;
	klex_pkg::token_t word_tok;
	klex_pkg::token_t own_tok;

	assign take     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ch_s1 <= ch;
		end
	end

	assign is_letter = (ch_s1 >= klex_pkg::CH_UC_A && ch_s1 <= klex_pkg::CH_UC_Z) ||
	                   (ch_s1 >= klex_pkg::CH_LC_A && ch_s1 <= klex_pkg::CH_LC_Z);
	assign is_space  = ch_s1 == klex_pkg::CH_SPACE || ch_s1 == klex_pkg::CH_TAB ||
	                   ch_s1 == klex_pkg::CH_LF || ch_s1 == klex_pkg::CH_CR;
	assign word_end  = in_word_q && !is_letter;
	assign own       = !is_letter && !is_space;

	always_comb begin
		kw_next = klex_pkg::KW_NONE;
		if (!in_word_q) begin
			if (ch_s1 == klex_pkg::CH_LC_I) begin
				kw_next = klex_pkg::KW_I;
			end else if (ch_s1 == klex_pkg::CH_LC_O) begin
				kw_next = klex_pkg::KW_O;
			end
		end else begin
			unique case (kw_q)
				klex_pkg::KW_I: begin
					if (ch_s1 == klex_pkg::CH_LC_N) kw_next = klex_pkg::KW_IN;
				end
				klex_pkg::KW_IN: begin
					if (ch_s1 == klex_pkg::CH_LC_T) kw_next = klex_pkg::KW_INT;
					else if (ch_s1 == klex_pkg::CH_LC_P) kw_next = klex_pkg::KW_INP;
				end
				klex_pkg::KW_INP: begin
					if (ch_s1 == klex_pkg::CH_LC_U) kw_next = klex_pkg::KW_INPU;
				end
				klex_pkg::KW_INPU: begin
					if (ch_s1 == klex_pkg::CH_LC_T) kw_next = klex_pkg::KW_INPUT;
				end
				klex_pkg::KW_O: begin
					if (ch_s1 == klex_pkg::CH_LC_U) kw_next = klex_pkg::KW_OU;
				end
				klex_pkg::KW_OU: begin
					if (ch_s1 == klex_pkg::CH_LC_T) kw_next = klex_pkg::KW_OUT;
				end
				klex_pkg::KW_OUT: begin
					if (ch_s1 == klex_pkg::CH_LC_P) kw_next = klex_pkg::KW_OUTP;
				end
				klex_pkg::KW_OUTP: begin
					if (ch_s1 == klex_pkg::CH_LC_U) kw_next = klex_pkg::KW_OUTPU;
				end
				klex_pkg::KW_OUTPU: begin
					if (ch_s1 == klex_pkg::CH_LC_T) kw_next = klex_pkg::KW_OUTPUT;
				end
				default: kw_next = klex_pkg::KW_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			count_q   <= '0;
			kw_q      <= klex_pkg::KW_NONE;
		end else if (take) begin
			if (is_letter) begin
				in_word_q <= 1'b1;
				kw_q      <= kw_next;
				if (!in_word_q) begin
					count_q <= 8'd1;
				end else if (count_q < MAX_LEN) begin
					count_q <= count_q + 8'd1;
				end
			end else begin
				in_word_q <= 1'b0;
				count_q   <= '0;
				kw_q      <= klex_pkg::KW_NONE;
			end
		end
	end

	always_comb begin
		word_tok.kind        = klex_pkg::KIND_IDENT;
		word_tok.word_length = count_q;
		word_tok.char_code   = '0;
		word_tok.last        = is_space;
		if (kw_q == klex_pkg::KW_INT) begin
			word_tok.kind = klex_pkg::KIND_INT;
		end else if (kw_q == klex_pkg::KW_INPUT) begin
			word_tok.kind = klex_pkg::KIND_INPUT;
		end else if (kw_q == klex_pkg::KW_OUTPUT) begin
			word_tok.kind = klex_pkg::KIND_OUTPUT;
		end

		own_tok.word_length = '0;
		own_tok.last        = 1'b1;
		own_tok.char_code   = ch_s1;
		priority if (ch_s1 == klex_pkg::CH_EQ) begin
			own_tok.kind = klex_pkg::KIND_ASSIGN;
		end else if (ch_s1 == klex_pkg::CH_COLON) begin
			own_tok.kind = klex_pkg::KIND_COLON;
		end else if (ch_s1 == klex_pkg::CH_NUL) begin
			own_tok.kind = klex_pkg::KIND_END;
		end else begin
			own_tok.kind = klex_pkg::KIND_INVALID;
		end
	end

	assign tok0   = word_end ? word_tok : own_tok;
	assign tok1   = own_tok;
	assign push_n = take ? (2'({1'b0, word_end}) + 2'({1'b0, own})) : 2'd0;

endmodule

### src/klex_tok_fifo.sv
// klex_tok_fifo: small token queue, up to two pushes and one pop per cycle.
// Depends on klex_pkg.
module klex_tok_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  klex_pkg::token_t  tok0,
	input  klex_pkg::token_t  tok1,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output klex_pkg::token_t  out_tok
);

	localparam int PW = $clog2(klex_pkg::QUEUE_DEPTH);
	localparam int CW = PW + 1;

	klex_pkg::token_t tok_mem_q [klex_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             pop;

	// room for two tokens, whatever leaves this cycle
	assign room      = cnt_q <= CW'(klex_pkg::QUEUE_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign out_tok   = tok_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			tok_mem_q[wr_ptr_q] <= tok0;
		end
		if (push_n == 2'd2) begin
			tok_mem_q[wr_ptr_q + PW'(1)] <= tok1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push_n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			cnt_q <= cnt_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule

### src/klex_checker.sv
// klex_checker: port-level checks on the lexer's output tokens.
// Depends on klex_pkg; bound to keyword_token_lexer.
module klex_checker #(
	parameter int MAX_WORD = 255
) (
	input logic       clk,
	input logic       arst_n,
	input logic [2:0] tok_kind,
	input logic [7:0] word_length,
	input logic [7:0] char_code,
	input logic       last,
	input logic       out_valid,
	input logic       out_ready
);

	localparam logic [7:0] MAX_LEN = 8'(MAX_WORD);

	// a stalled token holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tok_kind) &&
		$stable(word_length) && $stable(char_code) && $stable(last))
		else $error("output token changed while stalled");

	// word tokens carry a length in range and no byte
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tok_kind <= 3'(klex_pkg::KIND_OUTPUT) |->
		word_length != 8'd0 && word_length <= MAX_LEN && char_code == 8'd0)
		else $error("bad word token fields");

	// single-character tokens carry no length and are marked last
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tok_kind > 3'(klex_pkg::KIND_OUTPUT) |->
		word_length == 8'd0 && last)
		else $error("bad single-character token fields");

	// the byte code agrees with the kind
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
		(tok_kind == 3'(klex_pkg::KIND_ASSIGN)) == (char_code == klex_pkg::CH_EQ) &&
		(tok_kind != 3'(klex_pkg::KIND_COLON) || char_code == klex_pkg::CH_COLON) &&
		(tok_kind != 3'(klex_pkg::KIND_END) || char_code == klex_pkg::CH_NUL))
		else $error("char_code does not match token kind");

endmodule

bind keyword_token_lexer klex_checker #(
	.MAX_WORD(MAX_WORD)
) u_klex_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.tok_kind    (tok_kind),
	.word_length (word_length),
	.char_code   (char_code),
	.last        (last),
	.out_valid   (out_valid),
	.out_ready   (out_ready)
);

### tb/sv/keyword_token_lexer_test.sv
`timescale 1ns / 100ps
// keyword_token_lexer_test: self-checking bench for keyword_token_lexer.
// Byte stream in, tokens out, checked against an in-bench lexer model.
// Depends on klex_pkg and keyword_token_lexer.
module keyword_token_lexer_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_BYTES = 1500;

	// expected-token ledger: lexes each accepted byte and checks tokens in order
	class token_ledger;
		klex_pkg::token_t pending_tokens[$];
		bit               in_word;
		logic [7:0]       letter_count;
		klex_pkg::kw_t    prefix;
		int               errors;

		function new();
			in_word = 1'b0;
			letter_count = 8'd0;
			prefix = klex_pkg::KW_NONE;
			errors = 0;
		endfunction

		function bit is_letter(logic [7:0] c);
			return (c >= klex_pkg::CH_UC_A && c <= klex_pkg::CH_UC_Z) ||
				(c >= klex_pkg::CH_LC_A && c <= klex_pkg::CH_LC_Z);
		endfunction

		function bit is_blank(logic [7:0] c);
			return c == klex_pkg::CH_SPACE || c == klex_pkg::CH_TAB ||
				c == klex_pkg::CH_LF || c == klex_pkg::CH_CR;
		endfunction

		function klex_pkg::kw_t next_prefix(klex_pkg::kw_t p, logic [7:0] c);
			klex_pkg::kw_t n;
			n = klex_pkg::KW_NONE;
			case (p)
				klex_pkg::KW_I: begin
					if (c == klex_pkg::CH_LC_N) n = klex_pkg::KW_IN;
				end
				klex_pkg::KW_IN: begin
					if (c == klex_pkg::CH_LC_T) n = klex_pkg::KW_INT;
					else if (c == klex_pkg::CH_LC_P) n = klex_pkg::KW_INP;
				end
				klex_pkg::KW_INP: begin
					if (c == klex_pkg::CH_LC_U) n = klex_pkg::KW_INPU;
				end
				klex_pkg::KW_INPU: begin
					if (c == klex_pkg::CH_LC_T) n = klex_pkg::KW_INPUT;
				end
				klex_pkg::KW_O: begin
					if (c == klex_pkg::CH_LC_U) n = klex_pkg::KW_OU;
				end
				klex_pkg::KW_OU: begin
					if (c == klex_pkg::CH_LC_T) n = klex_pkg::KW_OUT;
				end
				klex_pkg::KW_OUT: begin
					if (c == klex_pkg::CH_LC_P) n = klex_pkg::KW_OUTP;
				end
				klex_pkg::KW_OUTP: begin
					if (c == klex_pkg::CH_LC_U) n = klex_pkg::KW_OUTPU;
				end
				klex_pkg::KW_OUTPU: begin
					if (c == klex_pkg::CH_LC_T) n = klex_pkg::KW_OUTPUT;
				end
				default: n = klex_pkg::KW_NONE;
			endcase
			return n;
		endfunction

		function void push(klex_pkg::kind_t k, logic [7:0] len, logic [7:0] code,
				logic lst);
			klex_pkg::token_t t;
			t.kind = k;
			t.word_length = len;
			t.char_code = code;
			t.last = lst;
			pending_tokens.push_back(t);
		endfunction

		function void lex_byte(logic [7:0] c);
			klex_pkg::kind_t k;
			if (is_letter(c)) begin
				if (!in_word) begin
					in_word = 1'b1;
					letter_count = 8'd1;
					prefix = (c == klex_pkg::CH_LC_I) ? klex_pkg::KW_I :
						((c == klex_pkg::CH_LC_O) ? klex_pkg::KW_O : klex_pkg::KW_NONE);
				end else begin
					if (letter_count < 8'd255)
						letter_count = letter_count + 8'd1;
					prefix = next_prefix(prefix, c);
				end
				return;
			end
			if (in_word) begin
				case (prefix)
					klex_pkg::KW_INT:    k = klex_pkg::KIND_INT;
					klex_pkg::KW_INPUT:  k = klex_pkg::KIND_INPUT;
					klex_pkg::KW_OUTPUT: k = klex_pkg::KIND_OUTPUT;
					default:             k = klex_pkg::KIND_IDENT;
				endcase
				push(k, letter_count, 8'd0, is_blank(c));
				in_word = 1'b0;
				letter_count = 8'd0;
				prefix = klex_pkg::KW_NONE;
			end
			if (is_blank(c))
				return;
			if (c == klex_pkg::CH_EQ)
				push(klex_pkg::KIND_ASSIGN, 8'd0, c, 1'b1);
			else if (c == klex_pkg::CH_COLON)
				push(klex_pkg::KIND_COLON, 8'd0, c, 1'b1);
			else if (c == klex_pkg::CH_NUL)
				push(klex_pkg::KIND_END, 8'd0, 8'd0, 1'b1);
			else
				push(klex_pkg::KIND_INVALID, 8'd0, c, 1'b1);
		endfunction

		function void check_token(klex_pkg::token_t got);
			klex_pkg::token_t want;
			if (pending_tokens.size() == 0) begin
				$display("%0t: unexpected token: expected none, actual kind=%0d len=%0d",
					$time, got.kind, got.word_length);
				errors++;
				return;
			end
			want = pending_tokens.pop_front();
			if (got.kind !== want.kind) begin
				$display("%0t: tok_kind mismatch: expected %0d, actual %0d",
					$time, want.kind, got.kind);
				errors++;
			end
			if (got.word_length !== want.word_length) begin
				$display("%0t: word_length mismatch: expected %0d, actual %0d",
					$time, want.word_length, got.word_length);
				errors++;
			end
			if (got.char_code !== want.char_code) begin
				$display("%0t: char_code mismatch: expected %0d, actual %0d",
					$time, want.char_code, got.char_code);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last mismatch: expected %0d, actual %0d",
					$time, want.last, got.last);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] ch = 8'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [2:0] tok_kind;
	logic [7:0] word_length;
	logic [7:0] char_code;
	logic       last;
	logic       out_valid;
	logic       out_ready = 1'b0;

	token_ledger ledger = new();
	int          cycles = 0;
	int          bytes_sent = 0;
	bit          calm = 1'b0;

	// words near and on the keywords, case variants included
	string vocab [0:17] = '{"int", "input", "output", "i", "in", "inp", "inpu", "o", "ou",
		"out", "outp", "outpu", "intx", "inputs", "outputs", "Int", "iNput", "OUTPUT"};

	keyword_token_lexer dut (
		.clk(clk),
		.arst_n(arst_n),
		.ch(ch),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.tok_kind(tok_kind),
		.word_length(word_length),
		.char_code(char_code),
		.last(last),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// token sink with random back-pressure
	initial begin
		int stall;
		klex_pkg::token_t got;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			got.kind = klex_pkg::kind_t'(tok_kind);
			got.word_length = word_length;
			got.char_code = char_code;
			got.last = last;
			ledger.check_token(got);
		end
	end

	// one byte transaction; returns at the accepting edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		@(negedge clk);
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		ch <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		ledger.lex_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_letters(input int len);
		logic [7:0] base;
		string hot;
		hot = "intoup";
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 1) == 0) begin
				send_byte(hot[$urandom_range(0, 5)]);
			end else begin
				base = ($urandom_range(0, 1) == 0) ? klex_pkg::CH_UC_A : klex_pkg::CH_LC_A;
				send_byte(base + 8'($urandom_range(0, 25)));
			end
		end
	endtask

	task automatic send_separator;
		int p;
		p = $urandom_range(0, 19);
		case (p)
			0, 1:    send_byte(klex_pkg::CH_SPACE);
			2, 3:    send_byte(klex_pkg::CH_TAB);
			4, 5:    send_byte(klex_pkg::CH_LF);
			6, 7:    send_byte(klex_pkg::CH_CR);
			8, 9, 10: send_byte(klex_pkg::CH_EQ);
			11, 12, 13: send_byte(klex_pkg::CH_COLON);
			14:      send_byte(klex_pkg::CH_NUL);
			default: send_byte(8'($urandom_range(0, 255)));
		endcase
	endtask

	// park the input until the queue of expected tokens is empty
	task automatic drain_tokens;
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.pending_tokens.size() != 0) @(posedge clk);
	endtask

	initial begin
		int pick;
		bit drained;
		drained = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// keywords ended by space, colon, =; ident by tab; high bytes; end of text
		send_text("int input:output=Io\t");
		send_byte(8'hFF);
		send_byte(8'h80);
		send_byte(klex_pkg::CH_COLON);
		send_byte(klex_pkg::CH_NUL);
		send_text("x\n");
		drain_tokens();

		// saturating word length
		send_letters(300);
		send_byte(klex_pkg::CH_SPACE);

		while (bytes_sent < RANDOM_BYTES) begin
			// alternate stretches with and without idling
			calm = ((bytes_sent / 250) % 3) == 1;
			if (!drained && bytes_sent > RANDOM_BYTES / 2) begin
				drain_tokens();
				drained = 1'b1;
			end
			pick = $urandom_range(0, 19);
			if (pick < 8)
				send_text(vocab[$urandom_range(0, 17)]);
			else if (pick < 16)
				send_letters($urandom_range(1, 8));
			else if (pick < 18)
				repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			else if ($urandom_range(0, 9) == 0)
				send_letters($urandom_range(250, 300));
			else
				send_letters($urandom_range(9, 20));
			send_separator();
		end

		calm = 1'b0;
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.pending_tokens.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (ledger.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

### files.f
src/klex_pkg.sv
src/klex_scan.sv
src/klex_tok_fifo.sv
src/keyword_token_lexer.sv
src/klex_checker.sv
tb/sv/keyword_token_lexer_test.sv
